// ===== hdl/bcs_pkg.sv =====
// bias calibration sequencer package: sizes, codes, phase encoding and
// the structs passed between the configuration, sequencing and output modules
// no dependencies
package bcs_pkg;

	localparam int DAC_BITS     = 12;
	localparam int SPAN_W       = DAC_BITS - 1;
	localparam int FIELD_W      = 12;
	localparam int SETTLE_W     = 4;
	localparam int SUM_W        = FIELD_W + 2;
	localparam int CMP_W        = 16;
	localparam int NUM_CAP      = 5;
	localparam int NUM_DRV      = 3;

	localparam logic [SETTLE_W-1:0] FIRST_SETTLE = SETTLE_W'(10);
	localparam logic [SETTLE_W-1:0] STEP_SETTLE  = SETTLE_W'(5);

	localparam logic [DAC_BITS-1:0] DAC_MAX     = {DAC_BITS{1'b1}};
	localparam logic [DAC_BITS-1:0] DAC_HALF    = {1'b1, {(DAC_BITS-1){1'b0}}};
	localparam logic [SPAN_W-1:0]   DAC_QUARTER = {1'b1, {(SPAN_W-1){1'b0}}};

	localparam logic [CMP_W-1:0] RANGE_LOW_NOM  = CMP_W'(500);
	localparam logic [CMP_W-1:0] RANGE_LOW_HIGH = CMP_W'(100);
	localparam logic [CMP_W-1:0] RANGE_TOP      = CMP_W'(3500);

	// captured code slots
	localparam logic [2:0] CAP_BORDER = 3'd0;
	localparam logic [2:0] CAP_G1_NOM = 3'd1;
	localparam logic [2:0] CAP_G2_NOM = 3'd2;
	localparam logic [2:0] CAP_G1_HI  = 3'd3;
	localparam logic [2:0] CAP_G2_HI  = 3'd4;

	// drive slots
	localparam logic [1:0] DRV_MAIN = 2'd0;
	localparam logic [1:0] DRV_G1   = 2'd1;
	localparam logic [1:0] DRV_G2   = 2'd2;

	typedef enum logic [2:0] {
		REG_VOLT_LOW      = 3'd0,
		REG_VOLT_HIGH     = 3'd1,
		REG_OFFSET_LIMIT  = 3'd2,
		REG_BORDER_STEP   = 3'd3,
		REG_BORDER_ACCEPT = 3'd4,
		REG_HIGH_TARGET   = 3'd5,
		REG_NOM_TARGET    = 3'd6,
		REG_ACCEPT_SLACK  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_BUSY = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	localparam logic [3:0] FS_NONE          = 4'd0;
	localparam logic [3:0] FS_VOLT          = 4'd1;
	localparam logic [3:0] FS_OFFSET        = 4'd2;
	localparam logic [3:0] FS_BORDER_RANGE  = 4'd3;
	localparam logic [3:0] FS_BORDER_CUR    = 4'd4;
	localparam logic [3:0] FS_G1H_RANGE     = 4'd5;
	localparam logic [3:0] FS_G1H_CUR       = 4'd6;
	localparam logic [3:0] FS_G2H_RANGE     = 4'd7;
	localparam logic [3:0] FS_G2H_CUR       = 4'd8;
	localparam logic [3:0] FS_G1N_RANGE     = 4'd9;
	localparam logic [3:0] FS_G1N_CUR       = 4'd10;
	localparam logic [3:0] FS_G2N_RANGE     = 4'd11;
	localparam logic [3:0] FS_G2N_CUR       = 4'd12;

	typedef enum logic [13:0] {
		PH_INIT      = 14'h0001,
		PH_VOLT      = 14'h0002,
		PH_OFFSET    = 14'h0004,
		PH_BORDER    = 14'h0008,
		PH_BORDER_OK = 14'h0010,
		PH_G1H       = 14'h0020,
		PH_G1H_OK    = 14'h0040,
		PH_G2H       = 14'h0080,
		PH_G2H_OK    = 14'h0100,
		PH_G1N       = 14'h0200,
		PH_G1N_OK    = 14'h0400,
		PH_G2N       = 14'h0800,
		PH_G2N_OK    = 14'h1000,
		PH_END       = 14'h2000
	} phase_t;

	typedef struct packed {
		logic [FIELD_W-1:0] volt_low;
		logic [FIELD_W-1:0] volt_high;
		logic [FIELD_W-1:0] offset_limit;
		logic [FIELD_W-1:0] border_step;
		logic [FIELD_W-1:0] border_accept;
		logic [FIELD_W-1:0] high_target;
		logic [FIELD_W-1:0] nom_target;
		logic [FIELD_W-1:0] accept_slack;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         fail_stage;
		logic [FIELD_W-1:0] main_bias_drive;
		logic [FIELD_W-1:0] gate1_drive;
		logic [FIELD_W-1:0] gate2_drive;
		logic               supply_enable;
		logic               supply_level;
		logic [FIELD_W-1:0] border_code;
		logic [FIELD_W-1:0] gate1_nominal_code;
		logic [FIELD_W-1:0] gate2_nominal_code;
		logic [FIELD_W-1:0] gate1_high_code;
		logic [FIELD_W-1:0] gate2_high_code;
	} res_t;

endpackage

// ===== hdl/bcs_cfg.sv =====
// configuration register file of the bias calibration sequencer
// depends on bcs_pkg
module bcs_cfg import bcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [FIELD_W-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_low      <= FIELD_W'(2250);
			cfg_q.volt_high     <= FIELD_W'(2550);
			cfg_q.offset_limit  <= FIELD_W'(20);
			cfg_q.border_step   <= FIELD_W'(10);
			cfg_q.border_accept <= FIELD_W'(40);
			cfg_q.high_target   <= FIELD_W'(600);
			cfg_q.nom_target    <= FIELD_W'(200);
			cfg_q.accept_slack  <= FIELD_W'(50);
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_VOLT_LOW:      cfg_q.volt_low      <= wr_data;
				REG_VOLT_HIGH:     cfg_q.volt_high     <= wr_data;
				REG_OFFSET_LIMIT:  cfg_q.offset_limit  <= wr_data;
				REG_BORDER_STEP:   cfg_q.border_step   <= wr_data;
				REG_BORDER_ACCEPT: cfg_q.border_accept <= wr_data;
				REG_HIGH_TARGET:   cfg_q.high_target   <= wr_data;
				REG_NOM_TARGET:    cfg_q.nom_target    <= wr_data;
				REG_ACCEPT_SLACK:  cfg_q.accept_slack  <= wr_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bcs_core.sv =====
// sequencing state of the calibration and its per-tick next-state logic
// depends on bcs_pkg
module bcs_core import bcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               start_req,
	input  logic [FIELD_W-1:0] bar_current,
	input  logic [FIELD_W-1:0] bar_voltage,
	input  cfg_t               cfg,
	output res_t               res
);

	phase_t                            phase_q,  phase_n;
	logic [SETTLE_W-1:0]               settle_q, settle_n;
	logic [DAC_BITS-1:0]               sval_q,   sval_n;
	logic [SPAN_W-1:0]                 span_q,   span_n;
	logic [FIELD_W-1:0]                off_q,    off_n;
	logic [FIELD_W-1:0]                bord_q,   bord_n;
	logic [NUM_CAP-1:0][DAC_BITS-1:0]  cap_q,    cap_n;
	logic [NUM_DRV-1:0][DAC_BITS-1:0]  drv_q,    drv_n;
	logic                              err_q,    err_n;
	logic [3:0]                        fail_q,   fail_n;
	logic                              sup_on_q, sup_on_n;
	logic                              sup_op_q, sup_op_n;

	// per-gate selections
	logic [1:0]          g_drv, g_oth;
	logic [2:0]          g_cap;
	logic [FIELD_W-1:0]  g_tgt;
	logic [CMP_W-1:0]    g_lo;
	logic [3:0]          g_stage;
	phase_t              g_next;
	logic                g_last;

	logic                waiting;
	logic [SUM_W-1:0]    off2, gate_sum;
	logic                up_border, up_gate, step_up, step_done, in_range;
	logic [DAC_BITS-1:0] step_val;
	logic [SPAN_W-1:0]   step_span;
	logic                busy;

	always_comb begin
		g_drv   = DRV_G1;
		g_oth   = DRV_G2;
		g_cap   = CAP_G1_HI;
		g_tgt   = cfg.high_target;
		g_lo    = RANGE_LOW_HIGH;
		g_stage = FS_G1H_RANGE;
		g_next  = PH_G1H_OK;
		g_last  = 1'b0;

		phase_n  = phase_q;
		settle_n = settle_q;
		sval_n   = sval_q;
		span_n   = span_q;
		off_n    = off_q;
		bord_n   = bord_q;
		cap_n    = cap_q;
		drv_n    = drv_q;
		err_n    = err_q;
		fail_n   = fail_q;
		sup_on_n = sup_on_q;
		sup_op_n = sup_op_q;

		if (settle_n != '0)
			settle_n = settle_n - SETTLE_W'(1);
		if (start_req) begin
			cap_n   = {NUM_CAP{DAC_MAX}};
			phase_n = PH_INIT;
		end
		waiting = (settle_n != '0);

		if (phase_n inside {PH_G1H, PH_G1H_OK}) begin
			g_stage = (phase_n == PH_G1H) ? FS_G1H_RANGE : FS_G1H_CUR;
			g_next  = (phase_n == PH_G1H) ? PH_G1H_OK : PH_G2H;
		end else if (phase_n inside {PH_G2H, PH_G2H_OK}) begin
			g_drv   = DRV_G2;
			g_oth   = DRV_G1;
			g_cap   = CAP_G2_HI;
			g_stage = (phase_n == PH_G2H) ? FS_G2H_RANGE : FS_G2H_CUR;
			g_next  = (phase_n == PH_G2H) ? PH_G2H_OK : PH_G1N;
		end else if (phase_n inside {PH_G1N, PH_G1N_OK}) begin
			g_cap   = CAP_G1_NOM;
			g_tgt   = cfg.nom_target;
			g_lo    = RANGE_LOW_NOM;
			g_stage = (phase_n == PH_G1N) ? FS_G1N_RANGE : FS_G1N_CUR;
			g_next  = (phase_n == PH_G1N) ? PH_G1N_OK : PH_G2N;
		end else if (phase_n inside {PH_G2N, PH_G2N_OK}) begin
			g_drv   = DRV_G2;
			g_oth   = DRV_G1;
			g_cap   = CAP_G2_NOM;
			g_tgt   = cfg.nom_target;
			g_lo    = RANGE_LOW_NOM;
			g_stage = (phase_n == PH_G2N) ? FS_G2N_RANGE : FS_G2N_CUR;
			g_next  = (phase_n == PH_G2N) ? PH_G2N_OK : PH_END;
			g_last  = 1'b1;
		end

		off2      = {1'b0, off_q, 1'b0};
		gate_sum  = SUM_W'(bord_q) + SUM_W'(g_tgt);
		up_border = SUM_W'(bar_current) > off2 + SUM_W'(cfg.border_step);
		up_gate   = SUM_W'(bar_current) > gate_sum;
		step_up   = (phase_n == PH_BORDER) ? up_border : up_gate;
		step_val  = step_up ? sval_q + DAC_BITS'(span_q) : sval_q - DAC_BITS'(span_q);
		step_span = span_q >> 1;
		step_done = (step_span == '0);
		in_range  = (CMP_W'(step_val) > g_lo) && (CMP_W'(step_val) < RANGE_TOP);

		case (phase_n)
			PH_INIT: begin
				err_n    = 1'b0;
				fail_n   = FS_NONE;
				sup_on_n = 1'b1;
				sup_op_n = 1'b0;
				drv_n    = {NUM_DRV{DAC_MAX}};
				settle_n = FIRST_SETTLE;
				phase_n  = PH_VOLT;
			end
			PH_VOLT: begin
				if (!waiting) begin
					if (bar_voltage > cfg.volt_low && bar_voltage < cfg.volt_high) begin
						off_n   = bar_current;
						phase_n = PH_OFFSET;
					end else begin
						sup_on_n = 1'b0;
						err_n    = 1'b1;
						fail_n   = FS_VOLT;
						phase_n  = PH_END;
					end
				end
			end
			PH_OFFSET: begin
				if (off_q < cfg.offset_limit) begin
					sval_n          = DAC_HALF;
					span_n          = DAC_QUARTER;
					drv_n[DRV_MAIN] = DAC_HALF;
					settle_n        = STEP_SETTLE;
					phase_n         = PH_BORDER;
				end else begin
					err_n   = 1'b1;
					fail_n  = FS_OFFSET;
					phase_n = PH_END;
				end
			end
			PH_BORDER: begin
				if (!waiting) begin
					sval_n          = step_val;
					span_n          = step_span;
					drv_n[DRV_MAIN] = step_val;
					if (step_done) begin
						cap_n[CAP_BORDER] = step_val;
						if ((CMP_W'(step_val) > RANGE_LOW_NOM) &&
						    (CMP_W'(step_val) < RANGE_TOP)) begin
							phase_n = PH_BORDER_OK;
						end else begin
							drv_n[DRV_MAIN] = DAC_MAX;
							err_n           = 1'b1;
							fail_n          = FS_BORDER_RANGE;
							phase_n         = PH_END;
						end
					end else begin
						settle_n = STEP_SETTLE;
					end
				end
			end
			PH_BORDER_OK: begin
				if (SUM_W'(bar_current) < off2 + SUM_W'(cfg.border_accept)) begin
					bord_n        = bar_current;
					sval_n        = DAC_HALF;
					span_n        = DAC_QUARTER;
					drv_n[DRV_G1] = DAC_HALF;
					settle_n      = STEP_SETTLE;
					phase_n       = PH_G1H;
				end else begin
					err_n   = 1'b1;
					fail_n  = FS_BORDER_CUR;
					phase_n = PH_END;
				end
			end
			PH_G1H, PH_G2H, PH_G1N, PH_G2N: begin
				if (!waiting) begin
					sval_n       = step_val;
					span_n       = step_span;
					drv_n[g_drv] = step_val;
					if (step_done) begin
						cap_n[g_cap] = step_val;
						if (in_range) begin
							phase_n = g_next;
						end else begin
							drv_n   = {NUM_DRV{DAC_MAX}};
							err_n   = 1'b1;
							fail_n  = g_stage;
							phase_n = PH_END;
						end
					end else begin
						settle_n = STEP_SETTLE;
					end
				end
			end
			PH_G1H_OK, PH_G2H_OK, PH_G1N_OK, PH_G2N_OK: begin
				if (SUM_W'(bar_current) < gate_sum + SUM_W'(cfg.accept_slack)) begin
					if (!g_last) begin
						drv_n[g_drv] = DAC_MAX;
						sval_n       = DAC_HALF;
						span_n       = DAC_QUARTER;
						drv_n[g_oth] = DAC_HALF;
						settle_n     = STEP_SETTLE;
						phase_n      = g_next;
					end else begin
						drv_n[DRV_MAIN] = cap_n[CAP_BORDER];
						drv_n[DRV_G1]   = cap_n[CAP_G1_NOM];
						drv_n[DRV_G2]   = cap_n[CAP_G2_NOM];
						sup_on_n        = 1'b1;
						sup_op_n        = 1'b1;
						phase_n         = PH_END;
					end
				end else begin
					drv_n   = {NUM_DRV{DAC_MAX}};
					err_n   = 1'b1;
					fail_n  = g_stage;
					phase_n = PH_END;
				end
			end
			default: begin
				// end phase, and any code outside the encoding, holds still
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_END;
			settle_q <= '0;
			sval_q   <= DAC_MAX;
			span_q   <= '0;
			off_q    <= '0;
			bord_q   <= '0;
			cap_q    <= {NUM_CAP{DAC_MAX}};
			drv_q    <= {NUM_DRV{DAC_MAX}};
			err_q    <= 1'b0;
			fail_q   <= FS_NONE;
			sup_on_q <= 1'b0;
			sup_op_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_n;
			settle_q <= settle_n;
			sval_q   <= sval_n;
			span_q   <= span_n;
			off_q    <= off_n;
			bord_q   <= bord_n;
			cap_q    <= cap_n;
			drv_q    <= drv_n;
			err_q    <= err_n;
			fail_q   <= fail_n;
			sup_on_q <= sup_on_n;
			sup_op_q <= sup_op_n;
		end
	end

	// result reflects the state after this transaction
	always_comb begin
		busy = phase_n inside {PH_INIT, PH_VOLT, PH_OFFSET, PH_BORDER, PH_BORDER_OK,
		                       PH_G1H, PH_G1H_OK, PH_G2H, PH_G2H_OK,
		                       PH_G1N, PH_G1N_OK, PH_G2N, PH_G2N_OK};
		if (err_n)
			res.status = ST_FAIL;
		else if (busy)
			res.status = ST_BUSY;
		else
			res.status = ST_IDLE;
		res.fail_stage         = fail_n;
		res.main_bias_drive    = FIELD_W'(drv_n[DRV_MAIN]);
		res.gate1_drive        = FIELD_W'(drv_n[DRV_G1]);
		res.gate2_drive        = FIELD_W'(drv_n[DRV_G2]);
		res.supply_enable      = sup_on_n;
		res.supply_level       = sup_op_n;
		res.border_code        = FIELD_W'(cap_n[CAP_BORDER]);
		res.gate1_nominal_code = FIELD_W'(cap_n[CAP_G1_NOM]);
		res.gate2_nominal_code = FIELD_W'(cap_n[CAP_G2_NOM]);
		res.gate1_high_code    = FIELD_W'(cap_n[CAP_G1_HI]);
		res.gate2_high_code    = FIELD_W'(cap_n[CAP_G2_HI]);
	end

endmodule

// ===== hdl/bcs_outbuf.sv =====
// output register of the bias calibration sequencer with its handshake
// depends on bcs_pkg
module bcs_outbuf import bcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic take,
	output logic full,
	output res_t res_out
);

	logic full_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			full_q <= 1'b0;
		else if (load)
			full_q <= 1'b1;
		else if (take)
			full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	assign full    = full_q;
	assign res_out = res_q;

endmodule

// ===== hdl/bias_calibration_sequencer_top.sv =====
// Bias calibration sequencer: one transaction per tick of measurement; the
// result of a tick appears in the output register on the next clock. An item
// is taken in every cycle while the output register is empty or being read
// in the same cycle, so the sustained rate is one item per clock; the whole
// step (compare, add or subtract, phase change) sits between the state
// registers and the output register. Configuration writes are taken at once.
// depends on bcs_pkg, bcs_cfg, bcs_core, bcs_outbuf
module bias_calibration_sequencer_top import bcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               start_req,
	input  logic [FIELD_W-1:0] bar_current,
	input  logic [FIELD_W-1:0] bar_voltage,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [3:0]         fail_stage,
	output logic [FIELD_W-1:0] main_bias_drive,
	output logic [FIELD_W-1:0] gate1_drive,
	output logic [FIELD_W-1:0] gate2_drive,
	output logic               supply_enable,
	output logic               supply_level,
	output logic [FIELD_W-1:0] border_code,
	output logic [FIELD_W-1:0] gate1_nominal_code,
	output logic [FIELD_W-1:0] gate2_nominal_code,
	output logic [FIELD_W-1:0] gate1_high_code,
	output logic [FIELD_W-1:0] gate2_high_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [FIELD_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res_next, res_reg;
	logic full, accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full || out_ready;
	assign accept    = in_valid && in_ready;

	bcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bcs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.start_req   (start_req),
		.bar_current (bar_current),
		.bar_voltage (bar_voltage),
		.cfg         (cfg),
		.res         (res_next)
	);

	bcs_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.res_in  (res_next),
		.take    (out_ready),
		.full    (full),
		.res_out (res_reg)
	);

	assign out_valid          = full;
	assign status             = res_reg.status;
	assign fail_stage         = res_reg.fail_stage;
	assign main_bias_drive    = res_reg.main_bias_drive;
	assign gate1_drive        = res_reg.gate1_drive;
	assign gate2_drive        = res_reg.gate2_drive;
	assign supply_enable      = res_reg.supply_enable;
	assign supply_level       = res_reg.supply_level;
	assign border_code        = res_reg.border_code;
	assign gate1_nominal_code = res_reg.gate1_nominal_code;
	assign gate2_nominal_code = res_reg.gate2_nominal_code;
	assign gate1_high_code    = res_reg.gate1_high_code;
	assign gate2_high_code    = res_reg.gate2_high_code;

endmodule
